### hw/rtl/radix_conv_pkg.sv
// ----------------------------------------------------------------------------
// Radix converter package
// Shared payload types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package radix_conv_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;

    typedef logic [1:0] base_t;
    localparam base_t BASE_BIN = 2'd0;
    localparam base_t BASE_OCT = 2'd1;
    localparam base_t BASE_DEC = 2'd2;
    localparam base_t BASE_HEX = 2'd3;

    localparam base_t SOURCE_BASE_RESET = BASE_DEC;
    localparam base_t GOAL_BASE_RESET   = BASE_BIN;

    typedef logic [1:0] cmd_code_t;
    localparam cmd_code_t CMD_NUMBER   = 2'd0;
    localparam cmd_code_t CMD_HEX_CHAR = 2'd1;
    localparam cmd_code_t CMD_HEX_END  = 2'd2;

    typedef logic [1:0] status_code_t;
    localparam status_code_t STATUS_OK       = 2'd0;
    localparam status_code_t STATUS_SAME     = 2'd1;
    localparam status_code_t STATUS_MISMATCH = 2'd2;

    localparam logic [VALUE_W-1:0] RECIP10  = 32'hCCCC_CCCD;
    localparam int                 RECIP_SH = 35;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;

    localparam logic [3:0] HEX_DIGITS = 4'd8;

    typedef struct packed {
        cmd_code_t          cmd;
        logic [VALUE_W-1:0] number;
        logic [CHAR_W-1:0]  hex_char;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CHAR_W-1:0]  out_char;
        logic               last;
        status_code_t       status;
    } out_t;

    typedef enum logic [3:0] {
        DP_NOP           = 4'd0,
        DP_START_IN      = 4'd1,
        DP_START_OUT_ACC = 4'd2,
        DP_START_OUT_HEX = 4'd3,
        DP_HEX_FOLD      = 4'd4,
        DP_DIV           = 4'd5,
        DP_ACC           = 4'd6,
        DP_HEX_LOAD      = 4'd7,
        DP_HEX_SHIFT     = 4'd8
    } dp_op_t;

    typedef enum logic [1:0] {
        EMIT_VALUE    = 2'd0,
        EMIT_CHAR     = 2'd1,
        EMIT_SAME     = 2'd2,
        EMIT_MISMATCH = 2'd3
    } emit_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
        emit_t  kind;
    } dp_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic top_zero;
        logic cnt_one;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/radix_conv_dp.sv
// ----------------------------------------------------------------------------
// Radix converter datapath
// Digit step unit (divide by radix, weight and accumulate), hex accumulator,
// hex character shifter and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_conv_dp (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  radix_conv_pkg::dp_cmd_t     cmd,
    input  radix_conv_pkg::in_t         s_data,
    input  radix_conv_pkg::base_t       source_base,
    input  radix_conv_pkg::base_t       goal_base,
    input  wire                         m_ready,
    output radix_conv_pkg::out_t        m_data,
    output logic                        m_valid,
    output radix_conv_pkg::dp_stat_t    stat
);

    logic [radix_conv_pkg::VALUE_W-1:0] n_reg, n_next;
    logic [radix_conv_pkg::VALUE_W-1:0] q_reg, q_next;
    logic [radix_conv_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [radix_conv_pkg::VALUE_W-1:0] w_reg, w_next;
    logic [radix_conv_pkg::VALUE_W-1:0] hex_acc_reg, hex_acc_next;
    radix_conv_pkg::base_t              div_reg, div_next;
    radix_conv_pkg::base_t              mul_reg, mul_next;
    logic [3:0]                         cnt_reg, cnt_next;
    radix_conv_pkg::out_t               out_reg, out_next;
    logic                               out_valid_reg, out_valid_next;

    logic [2*radix_conv_pkg::VALUE_W-1:0] recip_prod;
    logic [radix_conv_pkg::VALUE_W-1:0]   quot;
    logic [3:0]                           qd;
    logic [3:0]                           rem;
    logic [radix_conv_pkg::VALUE_W+3:0]   rem_w;
    logic [radix_conv_pkg::VALUE_W-1:0]   w_scaled;
    logic [radix_conv_pkg::VALUE_W-1:0]   hex_digit;
    logic [3:0]                           nib;
    logic [radix_conv_pkg::CHAR_W-1:0]    nib_char;
    logic                                 out_free;

    assign recip_prod = {{radix_conv_pkg::VALUE_W{1'b0}}, n_reg}
                      * {{radix_conv_pkg::VALUE_W{1'b0}}, radix_conv_pkg::RECIP10};

    always_comb begin
        case (div_reg)
            radix_conv_pkg::BASE_BIN: begin
                quot = n_reg >> 1;
                qd   = {q_reg[2:0], 1'b0};
            end
            radix_conv_pkg::BASE_OCT: begin
                quot = n_reg >> 3;
                qd   = {q_reg[0], 3'b000};
            end
            radix_conv_pkg::BASE_DEC: begin
                quot = {{radix_conv_pkg::RECIP_SH-radix_conv_pkg::VALUE_W{1'b0}},
                        recip_prod[2*radix_conv_pkg::VALUE_W-1:radix_conv_pkg::RECIP_SH]};
                qd   = {q_reg[2:0], 1'b0} + {q_reg[0], 3'b000};
            end
            default: begin
                quot = n_reg >> 4;
                qd   = 4'd0;
            end
        endcase
    end

    assign rem   = n_reg[3:0] - qd;
    assign rem_w = {4'd0, w_reg} * {{radix_conv_pkg::VALUE_W{1'b0}}, rem};

    always_comb begin
        case (mul_reg)
            radix_conv_pkg::BASE_BIN: w_scaled = w_reg << 1;
            radix_conv_pkg::BASE_OCT: w_scaled = w_reg << 3;
            radix_conv_pkg::BASE_DEC: w_scaled = (w_reg << 3) + (w_reg << 1);
            default:                  w_scaled = w_reg << 4;
        endcase
    end

    always_comb begin
        if (s_data.hex_char >= radix_conv_pkg::CHAR_ZERO &&
            s_data.hex_char <= radix_conv_pkg::CHAR_NINE) begin
            hex_digit = {24'd0, s_data.hex_char - radix_conv_pkg::CHAR_ZERO};
        end else begin
            hex_digit = {24'd0, s_data.hex_char} + 32'd10
                      - {24'd0, radix_conv_pkg::CHAR_LOW_A};
        end
    end

    assign nib = n_reg[radix_conv_pkg::VALUE_W-1 -: 4];

    always_comb begin
        if (nib <= 4'd9) begin
            nib_char = radix_conv_pkg::CHAR_ZERO + {4'd0, nib};
        end else begin
            nib_char = radix_conv_pkg::CHAR_LOW_A + {4'd0, nib} - 8'd10;
        end
    end

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        n_next       = n_reg;
        q_next       = q_reg;
        acc_next     = acc_reg;
        w_next       = w_reg;
        hex_acc_next = hex_acc_reg;
        div_next     = div_reg;
        mul_next     = mul_reg;
        cnt_next     = cnt_reg;
        case (cmd.op)
            radix_conv_pkg::DP_START_IN: begin
                n_next   = s_data.number;
                acc_next = '0;
                w_next   = 32'd1;
                div_next = radix_conv_pkg::BASE_DEC;
                mul_next = source_base;
            end
            radix_conv_pkg::DP_START_OUT_ACC: begin
                n_next   = acc_reg;
                acc_next = '0;
                w_next   = 32'd1;
                div_next = goal_base;
                mul_next = radix_conv_pkg::BASE_DEC;
            end
            radix_conv_pkg::DP_START_OUT_HEX: begin
                n_next       = hex_acc_reg;
                hex_acc_next = '0;
                acc_next     = '0;
                w_next       = 32'd1;
                div_next     = goal_base;
                mul_next     = radix_conv_pkg::BASE_DEC;
            end
            radix_conv_pkg::DP_HEX_FOLD: begin
                hex_acc_next = (hex_acc_reg << 4) + hex_digit;
            end
            radix_conv_pkg::DP_DIV: begin
                q_next = quot;
            end
            radix_conv_pkg::DP_ACC: begin
                acc_next = acc_reg + rem_w[radix_conv_pkg::VALUE_W-1:0];
                w_next   = w_scaled;
                n_next   = q_reg;
            end
            radix_conv_pkg::DP_HEX_LOAD: begin
                n_next   = acc_reg;
                cnt_next = radix_conv_pkg::HEX_DIGITS;
            end
            radix_conv_pkg::DP_HEX_SHIFT: begin
                n_next   = n_reg << 4;
                cnt_next = cnt_reg - 4'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next    = 1'b1;
            out_next.value    = '0;
            out_next.out_char = '0;
            out_next.last     = 1'b1;
            out_next.status   = radix_conv_pkg::STATUS_OK;
            case (cmd.kind)
                radix_conv_pkg::EMIT_VALUE: begin
                    out_next.value = acc_reg;
                end
                radix_conv_pkg::EMIT_CHAR: begin
                    out_next.out_char = nib_char;
                    out_next.last     = (cnt_reg == 4'd1);
                end
                radix_conv_pkg::EMIT_SAME: begin
                    out_next.status = radix_conv_pkg::STATUS_SAME;
                end
                default: begin
                    out_next.status = radix_conv_pkg::STATUS_MISMATCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        acc_reg <= acc_next;
        w_reg   <= w_next;
        div_reg <= div_next;
        mul_reg <= mul_next;
        cnt_reg <= cnt_next;
        out_reg <= out_next;
        if (!aresetn) begin
            hex_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hex_acc_reg   <= hex_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_data        = out_reg;
    assign m_valid       = out_valid_reg;
    assign stat.n_zero   = (n_reg == '0);
    assign stat.top_zero = (nib == 4'd0);
    assign stat.cnt_one  = (cnt_reg == 4'd1);
    assign stat.out_free = out_free;

endmodule

`default_nettype wire

### hw/rtl/radix_conv_ctrl.sv
// ----------------------------------------------------------------------------
// Radix converter controller
// Decodes each transaction and sequences the digit loops, hex character
// emission and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_conv_ctrl (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    input  radix_conv_pkg::cmd_code_t   s_cmd,
    input  radix_conv_pkg::base_t       source_base,
    input  radix_conv_pkg::base_t       goal_base,
    input  radix_conv_pkg::dp_stat_t    stat,
    output logic                        s_ready,
    output radix_conv_pkg::dp_cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV     = 6'b000010,
        ST_ACC     = 6'b000100,
        ST_HEXSKIP = 6'b001000,
        ST_HEXOUT  = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    pass_reg, pass_next;
    radix_conv_pkg::emit_t   kind_reg, kind_next;
    logic                    src_hex;

    assign src_hex = (source_base == radix_conv_pkg::BASE_HEX);
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        kind_next  = kind_reg;
        cmd.op     = radix_conv_pkg::DP_NOP;
        cmd.emit   = 1'b0;
        cmd.kind   = kind_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (source_base == goal_base) begin
                        kind_next  = radix_conv_pkg::EMIT_SAME;
                        state_next = ST_EMIT;
                    end else if (s_cmd == radix_conv_pkg::CMD_NUMBER && !src_hex) begin
                        cmd.op     = radix_conv_pkg::DP_START_IN;
                        pass_next  = 1'b0;
                        state_next = ST_DIV;
                    end else if (s_cmd == radix_conv_pkg::CMD_HEX_CHAR && src_hex) begin
                        cmd.op = radix_conv_pkg::DP_HEX_FOLD;
                    end else if (s_cmd == radix_conv_pkg::CMD_HEX_END && src_hex) begin
                        cmd.op     = radix_conv_pkg::DP_START_OUT_HEX;
                        pass_next  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        kind_next  = radix_conv_pkg::EMIT_MISMATCH;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_DIV: begin
                if (stat.n_zero) begin
                    if (pass_reg) begin
                        kind_next  = radix_conv_pkg::EMIT_VALUE;
                        state_next = ST_EMIT;
                    end else if (goal_base == radix_conv_pkg::BASE_HEX) begin
                        cmd.op     = radix_conv_pkg::DP_HEX_LOAD;
                        state_next = ST_HEXSKIP;
                    end else begin
                        cmd.op    = radix_conv_pkg::DP_START_OUT_ACC;
                        pass_next = 1'b1;
                    end
                end else begin
                    cmd.op     = radix_conv_pkg::DP_DIV;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.op     = radix_conv_pkg::DP_ACC;
                state_next = ST_DIV;
            end
            ST_HEXSKIP: begin
                if (stat.top_zero && !stat.cnt_one) begin
                    cmd.op = radix_conv_pkg::DP_HEX_SHIFT;
                end else begin
                    state_next = ST_HEXOUT;
                end
            end
            ST_HEXOUT: begin
                if (stat.out_free) begin
                    cmd.op   = radix_conv_pkg::DP_HEX_SHIFT;
                    cmd.emit = 1'b1;
                    cmd.kind = radix_conv_pkg::EMIT_CHAR;
                    if (stat.cnt_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        pass_reg <= pass_next;
        kind_reg <= kind_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/radix_converter_2_8_10_16.sv
// ----------------------------------------------------------------------------
// Radix converter, bases 2 / 8 / 10 / 16
// Top level: configuration registers, controller and datapath.
//
//   Channel  Ports                         Direction  Payload
//   s_       s_valid s_ready s_data        in         in_t  (cmd, number, hex_char)
//   m_       m_valid m_ready m_data        out        out_t (value, out_char, last, status)
//   apb      psel penable pwrite paddr...  in/out     source_base @0, goal_base @4
//
// Number conversions run a divide and accumulate loop per digit; number to hex
// then walks eight nibble slots, leading zeros skipped.
// Synchronous active-low reset clears the controller, hex accumulator and
// output valid; registers return to source decimal, goal binary.
// A full output register with m_ready low holds the controller; the next
// transaction is accepted once the last result of the current one is loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_converter_2_8_10_16 (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  radix_conv_pkg::in_t     s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output radix_conv_pkg::out_t    m_data,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [2:0]              paddr,
    input  wire  [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    radix_conv_pkg::base_t    source_base_reg;
    radix_conv_pkg::base_t    goal_base_reg;
    radix_conv_pkg::dp_cmd_t  dp_cmd;
    radix_conv_pkg::dp_stat_t dp_stat;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_base_reg <= radix_conv_pkg::SOURCE_BASE_RESET;
            goal_base_reg   <= radix_conv_pkg::GOAL_BASE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                goal_base_reg <= pwdata[1:0];
            end else begin
                source_base_reg <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2]) begin
            prdata = {30'd0, goal_base_reg};
        end else begin
            prdata = {30'd0, source_base_reg};
        end
    end

    radix_conv_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_cmd       (s_data.cmd),
        .source_base (source_base_reg),
        .goal_base   (goal_base_reg),
        .stat        (dp_stat),
        .s_ready     (s_ready),
        .cmd         (dp_cmd)
    );

    radix_conv_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (dp_cmd),
        .s_data      (s_data),
        .source_base (source_base_reg),
        .goal_base   (goal_base_reg),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .stat        (dp_stat)
    );

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Radix converter testbench
// Sweeps every source/goal radix pair over the APB port. Each pair gets random
// commands and numeric words, or hex strings for a hex source; most pairs see
// stalls on both channels. Results are checked against an in-bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam radix_conv_pkg::cmd_code_t CMD_RESERVED = 2'd3;
    localparam int unsigned REG_SOURCE_BASE   = 0;
    localparam int unsigned REG_GOAL_BASE     = 1;
    localparam int unsigned SETTLE_CYCLES     = 64;
    localparam int unsigned DRAIN_CYCLES      = 200;
    localparam int unsigned STALL_LIMIT       = 5000;
    localparam int unsigned ITEMS_PER_SETTING = 30;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    radix_conv_pkg::in_t   s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    radix_conv_pkg::out_t  m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [2:0]            paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    radix_converter_2_8_10_16 dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // model state
    radix_conv_pkg::base_t src_base  = radix_conv_pkg::SOURCE_BASE_RESET;
    radix_conv_pkg::base_t goal_base = radix_conv_pkg::GOAL_BASE_RESET;
    logic [31:0]           hex_acc   = '0;

    radix_conv_pkg::in_t   pending_items[$];
    radix_conv_pkg::out_t  expected_results[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned items_queued = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned hex_chars_checked = 0;
    int unsigned error_status_seen = 0;
    int unsigned settings_used = 1;
    int unsigned errors = 0;
    int unsigned stall_cycles = 0;

    function automatic logic [31:0] radix_value(radix_conv_pkg::base_t b);
        case (b)
            radix_conv_pkg::BASE_BIN: return 32'd2;
            radix_conv_pkg::BASE_OCT: return 32'd8;
            radix_conv_pkg::BASE_DEC: return 32'd10;
            default:                  return 32'd16;
        endcase
    endfunction

    // decimal-digit word weighted by radix r
    function automatic logic [31:0] read_digits(logic [31:0] n, logic [31:0] r);
        logic [31:0] acc;
        logic [31:0] weight;
        acc = '0;
        weight = 32'd1;
        while (n != 0) begin
            acc = acc + (n % 32'd10) * weight;
            weight = weight * r;
            n = n / 32'd10;
        end
        return acc;
    endfunction

    // value spelled as radix-r digits packed into a decimal word
    function automatic logic [31:0] write_digits(logic [31:0] n, logic [31:0] r);
        logic [31:0] acc;
        logic [31:0] weight;
        acc = '0;
        weight = 32'd1;
        while (n != 0) begin
            acc = acc + (n % r) * weight;
            weight = weight * 32'd10;
            n = n / r;
        end
        return acc;
    endfunction

    function automatic void push_result(logic [31:0] value, logic [7:0] ch, logic last,
                                        radix_conv_pkg::status_code_t status);
        radix_conv_pkg::out_t r;
        r.value = value;
        r.out_char = ch;
        r.last = last;
        r.status = status;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_conversion(radix_conv_pkg::in_t item);
        logic [31:0] v;
        logic [31:0] d;
        logic [3:0]  nib;
        int          top;
        int          k;
        if (src_base == goal_base) begin
            push_result('0, '0, 1'b1, radix_conv_pkg::STATUS_SAME);
        end else if (item.cmd == radix_conv_pkg::CMD_NUMBER &&
                     src_base != radix_conv_pkg::BASE_HEX) begin
            v = read_digits(item.number, radix_value(src_base));
            if (goal_base == radix_conv_pkg::BASE_HEX) begin
                top = 7;
                while (top > 0 && v[4*top +: 4] == 4'd0) top--;
                for (k = top; k >= 0; k--) begin
                    nib = v[4*k +: 4];
                    push_result('0, (nib <= 4'd9)
                                    ? radix_conv_pkg::CHAR_ZERO + 8'(nib)
                                    : radix_conv_pkg::CHAR_LOW_A + 8'(nib) - 8'd10,
                                k == 0, radix_conv_pkg::STATUS_OK);
                end
            end else begin
                push_result(write_digits(v, radix_value(goal_base)), '0, 1'b1,
                            radix_conv_pkg::STATUS_OK);
            end
        end else if (item.cmd == radix_conv_pkg::CMD_HEX_CHAR &&
                     src_base == radix_conv_pkg::BASE_HEX) begin
            if (item.hex_char >= radix_conv_pkg::CHAR_ZERO &&
                item.hex_char <= radix_conv_pkg::CHAR_NINE)
                d = 32'(item.hex_char - radix_conv_pkg::CHAR_ZERO);
            else
                d = 32'(item.hex_char) + 32'd10 - 32'(radix_conv_pkg::CHAR_LOW_A);
            hex_acc = (hex_acc << 4) + d;
        end else if (item.cmd == radix_conv_pkg::CMD_HEX_END &&
                     src_base == radix_conv_pkg::BASE_HEX) begin
            push_result(write_digits(hex_acc, radix_value(goal_base)), '0, 1'b1,
                        radix_conv_pkg::STATUS_OK);
            hex_acc = '0;
        end else begin
            push_result('0, '0, 1'b1, radix_conv_pkg::STATUS_MISMATCH);
        end
    endfunction

    function automatic void queue_item(radix_conv_pkg::cmd_code_t cmd, logic [31:0] number,
                                       logic [7:0] ch);
        radix_conv_pkg::in_t t;
        t.cmd = cmd;
        t.number = number;
        t.hex_char = ch;
        pending_items.push_back(t);
        items_queued++;
    endfunction

    task automatic apb_write(input int unsigned idx, input radix_conv_pkg::base_t b);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= {30'($urandom()), b};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SOURCE_BASE)
            src_base = b;
        else
            goal_base = b;
    endtask

    task automatic wait_idle();
        while (items_sent != items_queued || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_radices(input radix_conv_pkg::base_t src,
                               input radix_conv_pkg::base_t goal);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write(REG_SOURCE_BASE, src);
        apb_write(REG_GOAL_BASE, goal);
        settings_used++;
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_conversion(s_data);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin : result_check
        radix_conv_pkg::out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with none expected: %h", m_data);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_data.value);
                        errors++;
                    end
                    if (m_data.out_char !== want.out_char) begin
                        $error("out_char: expected %h, got %h", want.out_char, m_data.out_char);
                        errors++;
                    end
                    if (m_data.last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_data.last);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        errors++;
                    end
                    results_checked++;
                    if (want.out_char != 0) hex_chars_checked++;
                    if (want.status != radix_conv_pkg::STATUS_OK) error_status_seen++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // no progress while work is outstanding
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (items_sent == items_queued && expected_results.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        radix_conv_pkg::base_t pairs_src[16];
        radix_conv_pkg::base_t pairs_goal[16];
        radix_conv_pkg::base_t tmp;
        int          i;
        int          j;
        int          n;
        int          len;
        int unsigned pick;
        int unsigned mode;
        logic [63:0] word;
        logic [3:0]  nib;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 56;

        // decimal to binary after reset: extremes and wrong commands
        queue_item(radix_conv_pkg::CMD_NUMBER, 32'd0, 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_NUMBER, 32'hFFFF_FFFF, 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_NUMBER, 32'd1, 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_NUMBER, 32'd1010101, 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), "a");
        queue_item(radix_conv_pkg::CMD_HEX_END, $urandom(), 8'($urandom()));
        queue_item(CMD_RESERVED, $urandom(), 8'($urandom()));

        // zero and max to hex
        set_radices(radix_conv_pkg::BASE_DEC, radix_conv_pkg::BASE_HEX);
        queue_item(radix_conv_pkg::CMD_NUMBER, 32'd0, 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_NUMBER, 32'hFFFF_FFFF, 8'($urandom()));

        // hex strings, empty string, unchecked characters, wrong commands
        set_radices(radix_conv_pkg::BASE_HEX, radix_conv_pkg::BASE_BIN);
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), "f");
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), "f");
        queue_item(radix_conv_pkg::CMD_HEX_END, $urandom(), 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_HEX_END, $urandom(), 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), "g");
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), "A");
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), 8'h00);
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), 8'hFF);
        queue_item(radix_conv_pkg::CMD_HEX_END, $urandom(), 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_NUMBER, $urandom(), 8'($urandom()));
        queue_item(CMD_RESERVED, $urandom(), 8'($urandom()));

        // equal radices
        set_radices(radix_conv_pkg::BASE_OCT, radix_conv_pkg::BASE_OCT);
        queue_item(radix_conv_pkg::CMD_NUMBER, $urandom(), 8'($urandom()));
        queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(), 8'($urandom()));

        for (i = 0; i < 16; i++) begin
            pairs_src[i] = radix_conv_pkg::base_t'(i / 4);
            pairs_goal[i] = radix_conv_pkg::base_t'(i % 4);
        end
        for (i = 15; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = pairs_src[i];  pairs_src[i] = pairs_src[j];  pairs_src[j] = tmp;
            tmp = pairs_goal[i]; pairs_goal[i] = pairs_goal[j]; pairs_goal[j] = tmp;
        end

        for (i = 0; i < 16; i++) begin
            set_radices(pairs_src[i], pairs_goal[i]);
            mode = (i * 3) / 16;
            send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 56 : 0;
            recv_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 38 : 0;
            n = 0;
            while (n < ITEMS_PER_SETTING) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    queue_item(radix_conv_pkg::cmd_code_t'($urandom_range(3)), $urandom(),
                               8'($urandom()));
                    n++;
                end else if (pairs_src[i] == radix_conv_pkg::BASE_HEX) begin
                    len = $urandom_range(9);
                    for (j = 0; j < len; j++) begin
                        nib = 4'($urandom_range(15));
                        if ($urandom_range(99) < 85)
                            queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(),
                                       (nib <= 4'd9)
                                       ? radix_conv_pkg::CHAR_ZERO + 8'(nib)
                                       : radix_conv_pkg::CHAR_LOW_A + 8'(nib) - 8'd10);
                        else
                            queue_item(radix_conv_pkg::CMD_HEX_CHAR, $urandom(),
                                       8'($urandom()));
                    end
                    queue_item(radix_conv_pkg::CMD_HEX_END, $urandom(), 8'($urandom()));
                    n += len + 1;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 25) begin
                        word = 64'($urandom());
                    end else if (pick < 70) begin
                        word = '0;
                        len = $urandom_range(1, 10);
                        for (j = 0; j < len; j++)
                            word = word * 10 +
                                   64'($urandom_range(radix_value(pairs_src[i]) - 1));
                    end else if (pick < 85) begin
                        word = 64'($urandom_range(99));
                    end else if (pick < 93) begin
                        word = 64'(32'hFFFF_FFFF - $urandom_range(15));
                    end else begin
                        word = '0;
                    end
                    queue_item(radix_conv_pkg::CMD_NUMBER, word[31:0], 8'($urandom()));
                    n++;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors += expected_results.size();
        end

        $display("Run covered %0d input transactions over %0d radix settings,",
                 items_sent, settings_used);
        $display("with %0d results checked: %0d hex characters, %0d error statuses.",
                 results_checked, hex_chars_checked, error_status_seen);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
